FILE: rtl/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants of the strided tensor address block
// Holds field widths, register indexes, the sequencer state type and the
// link record that travels along the divider cell chain.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int IDX_BITS      = 32;
  localparam int OUT_ADDR_BITS = 48;
  localparam int SIZE_BITS     = 16;
  localparam int STRIDE_BITS   = 32;
  localparam int PROD_BITS     = SIZE_BITS + STRIDE_BITS;
  localparam int ITEM_BITS     = 4;
  localparam int DCNT_BITS     = 3;
  localparam int DIM_SLOTS     = 4;

  localparam int DEF_MAX_DIMS  = 4;
  localparam int DEF_ADDR_BITS = 48;

  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 6;

  typedef enum logic [2:0] {
    REG_BASE     = 3'd0,
    REG_ITEM     = 3'd1,
    REG_DCOUNT   = 3'd2,
    REG_DENSE    = 3'd3,
    REG_SIZES    = 3'd4,
    REG_STR_LOW  = 3'd5,
    REG_STR_HIGH = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAC,
    ST_SCALE,
    ST_DONE
  } state_t;

  // One dividend/quotient bit moving down the chain, MSB first.
  typedef struct packed {
    logic vld;
    logic last;
    logic bit_v;
  } link_t;

endpackage

FILE: rtl/sta_if.sv
// ----------------------------------------------------------------------------
// sta_if: stream channels of the strided tensor address block
// Index channel into the block and address channel out of it.
// ----------------------------------------------------------------------------
interface sta_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] linear_index;

  modport source (output valid, output linear_index, input ready);
  modport sink   (input valid, input linear_index, output ready);
endinterface

interface sta_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] byte_address;
  logic        size_error;

  modport source (output valid, output byte_address, output size_error, input ready);
  modport sink   (input valid, input byte_address, input size_error, output ready);
endinterface

FILE: rtl/sta_cell.sv
// ----------------------------------------------------------------------------
// sta_cell: one dimension of the bit-serial divider chain
// Takes dividend bits MSB first, keeps the running remainder (the coordinate)
// and hands each quotient bit to the next outer dimension in the next cycle.
// ----------------------------------------------------------------------------
module sta_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             active,
  input  logic [sta_pkg::SIZE_BITS-1:0]    size_i,
  input  sta_pkg::link_t                   link_i,
  output sta_pkg::link_t                   link_o,
  output logic [sta_pkg::SIZE_BITS-1:0]    rem_o
);
  import sta_pkg::*;

  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  link_t                link_r, link_nxt;
  logic [SIZE_BITS-1:0] divisor;
  logic [SIZE_BITS:0]   trial;
  logic                 ge;

  // An unused dimension divides by one: the remainder stays zero and the
  // bits pass through unchanged.
  assign divisor = active ? size_i : SIZE_BITS'(1);
  assign trial   = {rem_r, link_i.bit_v};
  assign ge      = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt        = rem_r;
    link_nxt.vld   = link_i.vld;
    link_nxt.last  = link_i.last;
    link_nxt.bit_v = ge;
    if (clear) begin
      rem_nxt      = '0;
      link_nxt.vld = 1'b0;
    end else if (link_i.vld) begin
      rem_nxt = ge ? SIZE_BITS'(trial - {1'b0, divisor}) : SIZE_BITS'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      link_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      link_r <= link_nxt;
    end
  end

  assign link_o = link_r;
  assign rem_o  = rem_r;

endmodule

FILE: rtl/strided_tensor_address.sv
// ----------------------------------------------------------------------------
// strided_tensor_address: linear element index to byte address
// Dense mode scales the index by the item size; strided mode splits it into
// coordinates in divider cells and scales the sum of coordinate * stride.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_if    | in        | valid/ready        | linear_index[31:0]
//  out_if   | out       | valid/ready        | byte_address[47:0], size_error
//  cfg      | in        | APB psel/penable   | paddr[5:0], pwdata/prdata[63:0]
//
// Strided items pass through the divider chain, one dividend bit a cycle and
// a register in each cell, then multiply-accumulate, then scale and done.
// Dense items and size errors go straight to scale and done. One item is in
// work at a time; the next is taken once the current one sits in the output
// register. A stalled output holds the finished item in the done state.
// Reset is synchronous, active low, and loads the register defaults.
// ----------------------------------------------------------------------------
module strided_tensor_address #(
  parameter int MAX_DIMS  = sta_pkg::DEF_MAX_DIMS,
  parameter int ADDR_BITS = sta_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sta_in_if.sink                              in_if,
  sta_out_if.source                           out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sta_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [sta_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [sta_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import sta_pkg::*;

  // Configuration registers.
  logic [OUT_ADDR_BITS-1:0] base_r;
  logic [ITEM_BITS-1:0]     item_r;
  logic [DCNT_BITS-1:0]     dcount_r;
  logic                     dense_r;
  logic [63:0]              sizes_r;
  logic [63:0]              str_low_r;
  logic [63:0]              str_high_r;
  reg_idx_t                 reg_sel;
  logic                     wr_en;

  assign reg_sel = reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      item_r     <= ITEM_BITS'(1);
      dcount_r   <= DCNT_BITS'(1);
      dense_r    <= 1'b1;
      sizes_r    <= 64'h0001_0001_0001_0001;
      str_low_r  <= '0;
      str_high_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BASE:     base_r     <= pwdata[OUT_ADDR_BITS-1:0];
        REG_ITEM:     item_r     <= pwdata[ITEM_BITS-1:0];
        REG_DCOUNT:   dcount_r   <= pwdata[DCNT_BITS-1:0];
        REG_DENSE:    dense_r    <= pwdata[0];
        REG_SIZES:    sizes_r    <= pwdata;
        REG_STR_LOW:  str_low_r  <= pwdata;
        REG_STR_HIGH: str_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE:     prdata = APB_DATA_BITS'(base_r);
      REG_ITEM:     prdata = APB_DATA_BITS'(item_r);
      REG_DCOUNT:   prdata = APB_DATA_BITS'(dcount_r);
      REG_DENSE:    prdata = APB_DATA_BITS'(dense_r);
      REG_SIZES:    prdata = sizes_r;
      REG_STR_LOW:  prdata = str_low_r;
      REG_STR_HIGH: prdata = str_high_r;
      default:      prdata = '0;
    endcase
  end

  // Per-dimension views of the registers.
  logic [SIZE_BITS-1:0]   dim_size [DIM_SLOTS];
  logic [STRIDE_BITS-1:0] dim_stride [DIM_SLOTS];
  logic [DCNT_BITS-1:0]   used;
  logic [DIM_SLOTS-1:0]   dim_used;
  logic                   size_bad;

  assign used = (dcount_r > DCNT_BITS'(MAX_DIMS)) ? DCNT_BITS'(MAX_DIMS) : dcount_r;

  always_comb begin
    for (int d = 0; d < DIM_SLOTS; d++) begin
      dim_size[d] = sizes_r[16*d +: 16];
      dim_used[d] = (d < MAX_DIMS) && (DCNT_BITS'(d) < used);
    end
    dim_stride[0] = str_low_r[31:0];
    dim_stride[1] = str_low_r[63:32];
    dim_stride[2] = str_high_r[31:0];
    dim_stride[3] = str_high_r[63:32];
    size_bad = 1'b0;
    for (int d = 0; d < DIM_SLOTS; d++) begin
      if (dim_used[d] && dim_size[d] == '0) size_bad = 1'b1;
    end
  end

  // Sequencer.
  state_t state_r, state_nxt;
  logic   in_fire;
  logic   out_load;
  logic   div_done;

  logic [IDX_BITS-1:0]  idx_sh_r;
  logic [5:0]           feed_cnt_r;
  link_t                feed_lnk;
  link_t                cell_lnk [MAX_DIMS];
  logic [SIZE_BITS-1:0] cell_rem [MAX_DIMS];
  logic                 cell_clear;

  localparam int MCNT_BITS = $clog2(MAX_DIMS + 1);
  logic [SIZE_BITS-1:0]   coord_sh_r  [MAX_DIMS];
  logic [STRIDE_BITS-1:0] stride_sh_r [MAX_DIMS];
  logic [MCNT_BITS-1:0]   mac_cnt_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [ADDR_BITS-1:0]   acc_r;
  logic [ADDR_BITS-1:0]   scl_r;
  logic                   err_r;

  logic                     out_valid_r;
  logic [OUT_ADDR_BITS-1:0] out_addr_r;
  logic                     out_err_r;

  assign in_fire  = in_if.valid && in_if.ready;
  assign div_done = cell_lnk[0].vld && cell_lnk[0].last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (dense_r || size_bad) state_nxt = ST_SCALE;
          else                     state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (div_done) state_nxt = ST_MAC;
      ST_MAC:   if (mac_cnt_r == MCNT_BITS'(MAX_DIMS)) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_r == ST_IDLE);
    out_load    = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);
    cell_clear  = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Dividend bits enter the innermost cell MSB first.
  assign feed_lnk.vld   = (state_r == ST_DIV) && (feed_cnt_r < 6'd32);
  assign feed_lnk.last  = (feed_cnt_r == 6'd31);
  assign feed_lnk.bit_v = idx_sh_r[IDX_BITS-1];

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      idx_sh_r   <= in_if.linear_index;
      feed_cnt_r <= '0;
    end else if (feed_lnk.vld) begin
      idx_sh_r   <= {idx_sh_r[IDX_BITS-2:0], 1'b0};
      feed_cnt_r <= feed_cnt_r + 6'd1;
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    link_t lnk_in;
    if (d == MAX_DIMS - 1) begin : g_top
      assign lnk_in = feed_lnk;
    end else begin : g_mid
      assign lnk_in = cell_lnk[d+1];
    end
    sta_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clear  (cell_clear),
      .active (dim_used[d]),
      .size_i (dim_size[d]),
      .link_i (lnk_in),
      .link_o (cell_lnk[d]),
      .rem_o  (cell_rem[d])
    );
  end

  // Offset accumulation: one coordinate * stride product a cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      acc_r     <= ADDR_BITS'(in_if.linear_index);
      err_r     <= !dense_r && size_bad;
      mac_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      acc_r     <= '0;
      mac_cnt_r <= '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord_sh_r[d]  <= dim_used[d] ? cell_rem[d] : '0;
        stride_sh_r[d] <= dim_stride[d];
      end
    end else if (state_r == ST_MAC) begin
      prod_r <= PROD_BITS'(coord_sh_r[0]) * PROD_BITS'(stride_sh_r[0]);
      for (int d = 0; d < MAX_DIMS - 1; d++) begin
        coord_sh_r[d]  <= coord_sh_r[d+1];
        stride_sh_r[d] <= stride_sh_r[d+1];
      end
      coord_sh_r[MAX_DIMS-1] <= '0;
      if (mac_cnt_r != '0) acc_r <= ADDR_BITS'(acc_r + ADDR_BITS'(prod_r));
      mac_cnt_r <= mac_cnt_r + MCNT_BITS'(1);
    end else if (state_r == ST_SCALE) begin
      scl_r <= err_r ? '0 : ADDR_BITS'(acc_r * ADDR_BITS'(item_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr_r <= OUT_ADDR_BITS'(ADDR_BITS'(ADDR_BITS'(base_r) + scl_r));
      out_err_r  <= err_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.byte_address = out_addr_r;
  assign out_if.size_error   = out_err_r;

endmodule
